### hdl/ntve_pkg.sv
// ----------------------------------------------------------------------------
// ntve_pkg
// Shared types, constants and index helpers for the n-tuple value unit.
// ----------------------------------------------------------------------------
package ntve_pkg;

  // Field widths fixed by the interface
  localparam int unsigned BOARD_W   = 64;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned DELTA_W   = 32;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned VALUE_W   = 37;
  localparam int unsigned LOAD_W    = 32;

  // Tap layout: eight line taps, then nine square taps
  localparam int unsigned NUM_LINES = 8;
  localparam int unsigned NUM_SQ    = 9;
  localparam int unsigned NUM_TAPS  = NUM_LINES + NUM_SQ;
  localparam int unsigned STEP_W    = $clog2(NUM_TAPS + 1);

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd164;

  // Bit offsets of the upper-left nibble of each 2x2 square
  localparam int unsigned SQ_OFF [NUM_SQ] = '{0, 4, 8, 16, 20, 24, 32, 36, 40};

  // Transpose masks
  localparam logic [63:0] TR_KEEP0 = 64'hF0F0_0F0F_F0F0_0F0F;
  localparam logic [63:0] TR_UP12  = 64'h0000_F0F0_0000_F0F0;
  localparam logic [63:0] TR_DN12  = 64'h0F0F_0000_0F0F_0000;
  localparam logic [63:0] TR_KEEP1 = 64'hFF00_FF00_00FF_00FF;
  localparam logic [63:0] TR_DN24  = 64'h00FF_00FF_0000_0000;
  localparam logic [63:0] TR_UP24  = 64'h0000_0000_FF00_FF00;

  typedef enum logic [1:0] {
    CMD_EVAL   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_e;

  // Read issue from sequencer to the weight memories
  typedef struct packed {
    logic             en;
    logic             tbl;   // 0 line table, 1 square table
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic             start; // item transfer: clear sum, latch change
    logic             load;  // single weight write
    logic             upd;   // current item is an update
    logic             proc;  // read data for a tap is valid this cycle
    logic             tbl;
    logic [IDX_W-1:0] addr;
  } ctl_t;

  // Transpose the 4x4 nibble board
  function automatic logic [63:0] flip_board(logic [63:0] x);
    logic [63:0] a;
    a = (x & TR_KEEP0) | ((x & TR_UP12) << 12) | ((x & TR_DN12) >> 12);
    return (a & TR_KEEP1) | ((a & TR_DN24) >> 24) | ((a & TR_UP24) << 24);
  endfunction

  // Gather the 2x2 square whose upper-left nibble sits at bit s
  function automatic logic [IDX_W-1:0] square_at(logic [63:0] b, int unsigned s);
    logic [63:0] sh;
    sh = b >> s;
    return {sh[23:20], sh[19:16], sh[7:4], sh[3:0]};
  endfunction

  // Table index of tap k for a board
  function automatic logic [IDX_W-1:0] tap_index(logic [63:0] b, logic [STEP_W-1:0] k);
    logic [63:0]                      t;
    logic [NUM_TAPS-1:0][IDX_W-1:0]   idx;
    t = flip_board(b);
    for (int i = 0; i < 4; i++) begin
      idx[i]     = b[16*i +: 16];
      idx[4 + i] = t[16*i +: 16];
    end
    for (int i = 0; i < NUM_SQ; i++) begin
      idx[NUM_LINES + i] = square_at(b, SQ_OFF[i]);
    end
    return (k < STEP_W'(NUM_TAPS)) ? idx[k] : '0;
  endfunction

endpackage

### hdl/ntve_wmem.sv
// ----------------------------------------------------------------------------
// ntve_wmem
// Weight table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ntve_wmem #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ntve_pkg::IDX_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [ntve_pkg::IDX_W-1:0] raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  localparam int unsigned DEPTH = 2 ** ntve_pkg::IDX_W;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ntve_seq.sv
// ----------------------------------------------------------------------------
// ntve_seq
// Item sequencer: holds the board, steps through the 17 taps and issues reads.
// ----------------------------------------------------------------------------
module ntve_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic [ntve_pkg::BOARD_W-1:0] board_i,
  input  logic                         out_free_i,
  output logic                         done_o,
  output ntve_pkg::rd_req_t            rd_o,
  output ntve_pkg::ctl_t               ctl_o
);

  ntve_pkg::seq_state_e             state_q, state_d;
  logic [ntve_pkg::STEP_W-1:0]      step_q, step_d;
  logic [ntve_pkg::BOARD_W-1:0]     board_q;
  logic                             upd_q;
  logic                             pvld_q, pvld_d;
  logic                             ptbl_q;
  logic [ntve_pkg::IDX_W-1:0]       paddr_q;
  logic                             xfer;
  logic                             issue;
  logic                             is_tap_cmd;
  ntve_pkg::cmd_e                   cmd;

  assign cmd        = ntve_pkg::cmd_e'(cmd_i);
  assign xfer       = in_valid_i && in_ready_o;
  assign is_tap_cmd = (cmd == ntve_pkg::CMD_EVAL) || (cmd == ntve_pkg::CMD_UPDATE);
  assign issue      = (state_q == ntve_pkg::ST_RUN)
                      && (step_q < ntve_pkg::STEP_W'(ntve_pkg::NUM_TAPS));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ntve_pkg::ST_IDLE: begin
        if (xfer) begin
          state_d = is_tap_cmd ? ntve_pkg::ST_RUN : ntve_pkg::ST_DONE;
        end
      end
      ntve_pkg::ST_RUN: begin
        if (!issue && pvld_q) begin
          state_d = ntve_pkg::ST_DONE;
        end
      end
      ntve_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = ntve_pkg::ST_IDLE;
        end
      end
      default: state_d = ntve_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    unique case (state_q)
      ntve_pkg::ST_IDLE: in_ready_o = 1'b1;
      ntve_pkg::ST_RUN:  ;
      ntve_pkg::ST_DONE: done_o = 1'b1;
      default:           ;
    endcase
  end

  // Step counter and pending tap
  always_comb begin
    step_d = step_q;
    pvld_d = issue;
    if (xfer) begin
      step_d = '0;
    end else if (issue) begin
      step_d = step_q + 1'b1;
    end
  end

  assign rd_o.en   = issue;
  assign rd_o.tbl  = (step_q >= ntve_pkg::STEP_W'(ntve_pkg::NUM_LINES));
  assign rd_o.addr = ntve_pkg::tap_index(board_q, step_q);

  assign ctl_o.start = xfer;
  assign ctl_o.load  = xfer && (cmd == ntve_pkg::CMD_LOAD);
  assign ctl_o.upd   = upd_q;
  assign ctl_o.proc  = pvld_q;
  assign ctl_o.tbl   = ptbl_q;
  assign ctl_o.addr  = paddr_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntve_pkg::ST_IDLE;
      step_q  <= '0;
      pvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pvld_q  <= pvld_d;
    end
  end

  // Hold the item and the address of the tap in flight
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      board_q <= board_i;
      upd_q   <= (cmd == ntve_pkg::CMD_UPDATE);
    end
    ptbl_q  <= rd_o.tbl;
    paddr_q <= rd_o.addr;
  end

endmodule

### hdl/ntve_alu.sv
// ----------------------------------------------------------------------------
// ntve_alu
// Datapath: change value, saturating weight update with forwarding, weight
// sum, and the write port mux for loads and updates.
// ----------------------------------------------------------------------------
module ntve_alu #(
  parameter int unsigned WEIGHT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ntve_pkg::ctl_t                      ctl_i,
  input  logic [ntve_pkg::RATE_W-1:0]         learn_rate_i,
  input  logic signed [ntve_pkg::DELTA_W-1:0] delta_i,
  input  logic                                table_select_i,
  input  logic [ntve_pkg::IDX_W-1:0]          weight_index_i,
  input  logic signed [ntve_pkg::LOAD_W-1:0]  weight_value_i,
  input  logic [WEIGHT_WIDTH-1:0]             rd_line_i,
  input  logic [WEIGHT_WIDTH-1:0]             rd_sq_i,
  output logic                                we_line_o,
  output logic                                we_sq_o,
  output logic [ntve_pkg::IDX_W-1:0]          waddr_o,
  output logic [WEIGHT_WIDTH-1:0]             wdata_o,
  output logic signed [ntve_pkg::VALUE_W-1:0] sum_o
);

  localparam int unsigned WW     = WEIGHT_WIDTH;
  localparam int unsigned EXT_W  = ((WW > ntve_pkg::LOAD_W) ? WW : ntve_pkg::LOAD_W) + 1;
  localparam int unsigned ACC_W  = ((WW + 5) > ntve_pkg::VALUE_W) ? (WW + 5)
                                                                  : ntve_pkg::VALUE_W;
  localparam int unsigned PROD_W = ntve_pkg::RATE_W + ntve_pkg::DELTA_W + 1;

  localparam logic signed [EXT_W-1:0] W_MAX = {{(EXT_W - WW + 1){1'b0}}, {(WW - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] W_MIN = ~W_MAX;
  localparam logic signed [ACC_W-1:0] V_MAX =
    {{(ACC_W - ntve_pkg::VALUE_W + 1){1'b0}}, {(ntve_pkg::VALUE_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] V_MIN = ~V_MAX;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(32768);

  logic signed [ntve_pkg::DELTA_W-1:0] change_q;
  logic signed [PROD_W-1:0]            prod;
  logic signed [PROD_W-1:0]            prod_rnd;
  logic signed [ACC_W-1:0]             acc_q, acc_d;
  logic                                fw_vld_q;
  logic                                fw_tbl_q;
  logic [ntve_pkg::IDX_W-1:0]          fw_addr_q;
  logic [WW-1:0]                       fw_val_q;
  logic                                fwd;
  logic signed [WW-1:0]                data;
  logic signed [EXT_W-1:0]             upd_sum;
  logic [WW-1:0]                       upd_val;
  logic [WW-1:0]                       load_val;
  logic                                upd_we;

  function automatic logic [WW-1:0] sat_w(logic signed [EXT_W-1:0] v);
    if (v > W_MAX) begin
      return W_MAX[WW-1:0];
    end else if (v < W_MIN) begin
      return W_MIN[WW-1:0];
    end
    return v[WW-1:0];
  endfunction

  // Change = rate * delta, rounded half up to Q16.16
  assign prod     = $signed({1'b0, learn_rate_i}) * delta_i;
  assign prod_rnd = prod + HALF;

  // Forward the value written last cycle when the same entry is read back
  assign fwd  = fw_vld_q && (fw_addr_q == ctl_i.addr) && (fw_tbl_q == ctl_i.tbl);
  assign data = fwd ? $signed(fw_val_q) : $signed(ctl_i.tbl ? rd_sq_i : rd_line_i);

  // Saturating weight update
  assign upd_sum  = EXT_W'(data) + EXT_W'(change_q);
  assign upd_val  = sat_w(upd_sum);
  assign upd_we   = ctl_i.proc && ctl_i.upd;
  assign load_val = sat_w(EXT_W'(weight_value_i));

  // Write port: loads come only while no tap is in flight
  assign we_line_o = (upd_we && !ctl_i.tbl) || (ctl_i.load && !table_select_i);
  assign we_sq_o   = (upd_we && ctl_i.tbl) || (ctl_i.load && table_select_i);
  assign waddr_o   = ctl_i.load ? weight_index_i : ctl_i.addr;
  assign wdata_o   = ctl_i.load ? load_val : upd_val;

  // Accumulate for evaluate
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.start) begin
      acc_d = '0;
    end else if (ctl_i.proc && !ctl_i.upd) begin
      acc_d = acc_q + ACC_W'(data);
    end
  end

  // Clamp the sum to the result range
  always_comb begin
    if (acc_q > V_MAX) begin
      sum_o = V_MAX[ntve_pkg::VALUE_W-1:0];
    end else if (acc_q < V_MIN) begin
      sum_o = V_MIN[ntve_pkg::VALUE_W-1:0];
    end else begin
      sum_o = acc_q[ntve_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_vld_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      fw_vld_q <= upd_we;
      acc_q    <= acc_d;
    end
  end

  // Latch change at transfer; hold the last written entry for forwarding
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      change_q <= prod_rnd[ntve_pkg::DELTA_W+15:16];
    end
    fw_tbl_q  <= ctl_i.tbl;
    fw_addr_q <= ctl_i.addr;
    fw_val_q  <= upd_val;
  end

endmodule

### hdl/ntuple_value_eval_update_unit.sv
// ----------------------------------------------------------------------------
// ntuple_value_eval_update_unit
// N-tuple value function: evaluate, TD update and load of two weight tables.
// ----------------------------------------------------------------------------
// Evaluate and update: the 17 taps go one per cycle through the weight table
// read ports. Load and no-op go straight to the result without a table read.
// An item is accepted only after the previous result is registered for output.
// Reset clears control state and sets learn_rate to 164; weight tables are
// undefined until written.
module ntuple_value_eval_update_unit #(
  parameter int unsigned WEIGHT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                learn_rate_we_i,
  input  logic [ntve_pkg::RATE_W-1:0]         learn_rate_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [ntve_pkg::BOARD_W-1:0]        board_i,
  input  logic signed [ntve_pkg::DELTA_W-1:0] delta_i,
  input  logic                                table_select_i,
  input  logic [ntve_pkg::IDX_W-1:0]          weight_index_i,
  input  logic signed [ntve_pkg::LOAD_W-1:0]  weight_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ntve_pkg::VALUE_W-1:0] value_o
);

  logic [ntve_pkg::RATE_W-1:0]         learn_rate_q;
  logic                                out_valid_q;
  logic signed [ntve_pkg::VALUE_W-1:0] value_q;
  logic                                out_free;
  logic                                done;
  ntve_pkg::rd_req_t                   rd;
  ntve_pkg::ctl_t                      ctl;
  logic                                we_line, we_sq;
  logic [ntve_pkg::IDX_W-1:0]          waddr;
  logic [WEIGHT_WIDTH-1:0]             wdata;
  logic [WEIGHT_WIDTH-1:0]             rd_line, rd_sq;
  logic signed [ntve_pkg::VALUE_W-1:0] sum;

  assign out_free = !out_valid_q || out_ready_i;

  ntve_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .board_i    (board_i),
    .out_free_i (out_free),
    .done_o     (done),
    .rd_o       (rd),
    .ctl_o      (ctl)
  );

  ntve_alu #(
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_alu (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .learn_rate_i   (learn_rate_q),
    .delta_i        (delta_i),
    .table_select_i (table_select_i),
    .weight_index_i (weight_index_i),
    .weight_value_i (weight_value_i),
    .rd_line_i      (rd_line),
    .rd_sq_i        (rd_sq),
    .we_line_o      (we_line),
    .we_sq_o        (we_sq),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .sum_o          (sum)
  );

  ntve_wmem #(
    .WIDTH (WEIGHT_WIDTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (we_line),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd.en && !rd.tbl),
    .raddr_i (rd.addr),
    .rdata_o (rd_line)
  );

  ntve_wmem #(
    .WIDTH (WEIGHT_WIDTH)
  ) u_sq_mem (
    .clk_i   (clk_i),
    .we_i    (we_sq),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd.en && rd.tbl),
    .raddr_i (rd.addr),
    .rdata_o (rd_sq)
  );

  // Learning rate register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q <= ntve_pkg::RATE_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (learn_rate_we_i) begin
        learn_rate_q <= learn_rate_i;
      end
      if (done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      value_q <= sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule
